>>> hw/rtl/cls_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cls_pkg: shared types and constants for the Collatz length search
// Word layouts of the item and result channels and the fixed field widths.
// ----------------------------------------------------------------------------
package cls_pkg;

	localparam int unsigned MEMO_ENTRIES_DEF = 65536;
	localparam int unsigned PATH_DEPTH_DEF   = 1024;

	localparam int VAL_W   = 63;
	localparam int LEN_W   = 16;
	localparam int TERMS_W = 32;

	// odd values above this bound no longer have a 3x+1 that fits a signed 64-bit word
	localparam logic [VAL_W-1:0] ODD_LIMIT = 63'h2AAA_AAAA_AAAA_AAAA;
	localparam logic [LEN_W-1:0] LEN_MAX   = '1;

	typedef struct packed {
		logic [VAL_W-1:0] start_value;
		logic             new_search;
	} cls_item_t;

	typedef struct packed {
		logic [LEN_W-1:0] seq_length;
		logic             overflowed;
		logic [VAL_W-1:0] best_start;
		logic [LEN_W-1:0] best_length;
	} cls_result_t;

endpackage
`default_nettype wire

>>> hw/rtl/cls_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cls_stream_if: valid/ready channel
// Carries one word per handshake; a word moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface cls_stream_if #(
	parameter type word_t = logic
) ();
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/cls_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cls_ram: simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cls_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> hw/rtl/collatz_length_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// collatz_length_search: Collatz sequence length with memo and best tracking
// Walks the Collatz rule per start value, memoizes lengths of small values.
// ----------------------------------------------------------------------------
// After reset the block sweeps the length memo to zero, one entry per cycle,
// and takes no item until that is done. An item is then taken in S_IDLE and
// walked one Collatz step at a time: values at or above MEMO_ENTRIES step in
// S_STEP, smaller values first look up the memo in S_LOOK and step there on a
// miss. The walk ends when S_STEP sees the value reach 1, on a memo hit after
// its lookup, or on the cycle that finds an overflow.
// The recorded path is then written back into the memo; an overflow skips it.
// The result register is loaded once it holds no unread word or that word is
// taken. One item is in work at a time. A finished result waits in the output
// register while the next item is taken and walked.
module collatz_length_search #(
	parameter int unsigned MEMO_ENTRIES = cls_pkg::MEMO_ENTRIES_DEF,
	parameter int unsigned PATH_DEPTH   = cls_pkg::PATH_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	cls_stream_if.sink   item,
	cls_stream_if.source result
);
	import cls_pkg::*;

	localparam int MEMO_AW = $clog2(MEMO_ENTRIES);
	localparam int PATH_AW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
	localparam int PCNT_W  = $clog2(PATH_DEPTH + 1);

	localparam logic [MEMO_AW-1:0] MEMO_LAST  = MEMO_AW'(MEMO_ENTRIES - 1);
	localparam logic [VAL_W-1:0]   MEMO_LIMIT = VAL_W'(MEMO_ENTRIES);
	localparam logic [PCNT_W-1:0]  PATH_FULL  = PCNT_W'(PATH_DEPTH);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_STEP  = 3'd2;
	localparam logic [2:0] S_LOOK  = 3'd3;
	localparam logic [2:0] S_WB    = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	logic [2:0]         state_q;
	logic [MEMO_AW-1:0] clr_q;
	logic [VAL_W-1:0]   x_q;
	logic [VAL_W-1:0]   start_q;
	logic [TERMS_W-1:0] terms_q;
	logic               ovf_q;
	logic [PCNT_W-1:0]  pcnt_q;
	logic [PCNT_W-1:0]  wb_q;
	logic               wb_vld_s1;
	logic [PCNT_W-1:0]  wb_idx_s1;
	logic [VAL_W-1:0]   best_val_q;
	logic [LEN_W-1:0]   best_len_q;
	logic               out_vld_q;
	cls_result_t        out_data_q;

	logic [LEN_W-1:0]   memo_rdata;
	logic [MEMO_AW-1:0] path_rdata;
	logic               memo_we;
	logic [MEMO_AW-1:0] memo_waddr;
	logic [LEN_W-1:0]   memo_wdata;
	logic               path_we;

	logic               accept;
	logic               x_le1;
	logic               x_small;
	logic               memo_hit;
	logic               adv_step;
	logic               odd_ovf;
	logic [VAL_W+1:0]   x_tpl;
	logic [VAL_W-1:0]   x_next;
	logic [TERMS_W-1:0] terms_inc;
	logic [TERMS_W:0]   terms_sum;
	logic [TERMS_W-1:0] terms_add;
	logic [TERMS_W-1:0] wb_diff;
	logic [LEN_W-1:0]   wb_len;
	logic [LEN_W-1:0]   fin_len;
	logic               fin_better;
	logic               fin_load;

	assign accept   = item.valid && item.ready;
	assign x_le1    = (x_q[VAL_W-1:1] == '0);
	assign x_small  = (x_q < MEMO_LIMIT);
	assign memo_hit = (memo_rdata != '0);
	assign adv_step = ((state_q == S_STEP) && !x_le1 && !x_small) ||
	                  ((state_q == S_LOOK) && !memo_hit);

	// one Collatz step
	assign odd_ovf   = x_q[0] && (x_q > ODD_LIMIT);
	assign x_tpl     = {2'b00, x_q} + {1'b0, x_q, 1'b0} + (VAL_W+2)'(1);
	assign x_next    = x_q[0] ? x_tpl[VAL_W-1:0] : {1'b0, x_q[VAL_W-1:1]};
	assign terms_inc = (terms_q == '1) ? terms_q : terms_q + TERMS_W'(1);
	assign terms_sum = {1'b0, terms_q} + (TERMS_W+1)'(memo_rdata);
	assign terms_add = terms_sum[TERMS_W] ? '1 : terms_sum[TERMS_W-1:0];

	// remaining length for path entry i: terms - i - 1, saturated
	assign wb_diff = terms_q - TERMS_W'(wb_idx_s1) - TERMS_W'(1);
	assign wb_len  = (wb_diff > TERMS_W'(LEN_MAX)) ? LEN_MAX : wb_diff[LEN_W-1:0];

	assign fin_len    = ovf_q ? '0 :
	                    ((terms_q > TERMS_W'(LEN_MAX)) ? LEN_MAX : terms_q[LEN_W-1:0]);
	assign fin_better = !ovf_q && (fin_len > best_len_q);
	assign fin_load   = (state_q == S_FIN) && (!out_vld_q || result.ready);

	// memo is written only in the clear sweep and the writeback; its read data
	// is used only during the walk, so no access overlap needs forwarding
	assign memo_we    = (state_q == S_CLEAR) || ((state_q == S_WB) && wb_vld_s1);
	assign memo_waddr = (state_q == S_CLEAR) ? clr_q : path_rdata;
	assign memo_wdata = (state_q == S_CLEAR) ? '0 : wb_len;
	assign path_we    = (state_q == S_LOOK) && !memo_hit && (pcnt_q != PATH_FULL);

	cls_ram #(
		.WIDTH (LEN_W),
		.DEPTH (MEMO_ENTRIES),
		.AW    (MEMO_AW)
	) u_memo (
		.clk   (clk),
		.we    (memo_we),
		.waddr (memo_waddr),
		.wdata (memo_wdata),
		.raddr (x_q[MEMO_AW-1:0]),
		.rdata (memo_rdata)
	);

	cls_ram #(
		.WIDTH (MEMO_AW),
		.DEPTH (PATH_DEPTH),
		.AW    (PATH_AW)
	) u_path (
		.clk   (clk),
		.we    (path_we),
		.waddr (pcnt_q[PATH_AW-1:0]),
		.wdata (x_q[MEMO_AW-1:0]),
		.raddr (wb_q[PATH_AW-1:0]),
		.rdata (path_rdata)
	);

	assign item.ready   = (state_q == S_IDLE);
	assign result.valid = out_vld_q;
	assign result.data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			pcnt_q     <= '0;
			wb_q       <= '0;
			wb_vld_s1  <= 1'b0;
			best_val_q <= '0;
			best_len_q <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if (fin_load) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + MEMO_AW'(1);
					if (clr_q == MEMO_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (item.valid) begin
						pcnt_q <= '0;
						if (item.data.new_search) begin
							best_val_q <= '0;
							best_len_q <= '0;
						end
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					if (x_le1) begin
						wb_q      <= '0;
						wb_vld_s1 <= 1'b0;
						state_q   <= S_WB;
					end else if (x_small) begin
						state_q <= S_LOOK;
					end else if (odd_ovf) begin
						state_q <= S_FIN;
					end
				end
				S_LOOK: begin
					if (memo_hit) begin
						wb_q      <= '0;
						wb_vld_s1 <= 1'b0;
						state_q   <= S_WB;
					end else begin
						if (pcnt_q != PATH_FULL) begin
							pcnt_q <= pcnt_q + PCNT_W'(1);
						end
						state_q <= odd_ovf ? S_FIN : S_STEP;
					end
				end
				S_WB: begin
					// read path entry wb_q, write its memo entry from the registered read data
					wb_vld_s1 <= (wb_q != pcnt_q);
					if (wb_q != pcnt_q) begin
						wb_q <= wb_q + PCNT_W'(1);
					end else if (!wb_vld_s1) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_load) begin
						if (fin_better) begin
							best_val_q <= start_q;
							best_len_q <= fin_len;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		wb_idx_s1 <= wb_q;
		if (accept) begin
			x_q     <= item.data.start_value;
			start_q <= item.data.start_value;
			terms_q <= TERMS_W'(1);
			ovf_q   <= 1'b0;
		end
		if (adv_step) begin
			if (odd_ovf) begin
				ovf_q <= 1'b1;
			end else begin
				x_q     <= x_next;
				terms_q <= terms_inc;
			end
		end
		if ((state_q == S_LOOK) && memo_hit) begin
			terms_q <= terms_add;
		end
		if (fin_load) begin
			out_data_q.seq_length  <= fin_len;
			out_data_q.overflowed  <= ovf_q;
			out_data_q.best_start  <= fin_better ? start_q : best_val_q;
			out_data_q.best_length <= fin_better ? fin_len : best_len_q;
		end
	end

	a_memo_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		memo_we |-> (state_q == S_CLEAR || state_q == S_WB))
		else $error("memo written outside clear sweep or writeback");

	a_path_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pcnt_q <= PATH_FULL)
		else $error("path count beyond path store depth");

	a_ovf_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.data.overflowed) |-> (result.data.seq_length == '0))
		else $error("overflowed result with nonzero length");

	a_best_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |=> (best_len_q >= $past(best_len_q)))
		else $error("best length dropped outside a new search");

endmodule
`default_nettype wire
